// File: src/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the fixed-point calculator with nth root.
// ----------------------------------------------------------------------------
package frc_pkg;

   // Default parameter values.
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int MAX_INDEX_DEF  = 31;

   // Configuration registers.
   localparam int TOL_WIDTH   = 16;
   localparam int ITER_WIDTH  = 8;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_IDX_W   = 1;
   localparam logic [TOL_WIDTH-1:0]  TOL_RESET  = 16'd1;
   localparam logic [ITER_WIDTH-1:0] ITER_RESET = 8'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TOLERANCE      = 1'b0,
      REG_MAX_ITERATIONS = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_POW  = 3'd4,
      OP_ROOT = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_DIV_ZERO     = 3'd1,
      ST_BAD_EXP      = 3'd2,
      ST_NEG_RADICAND = 3'd3,
      ST_BAD_INDEX    = 3'd4,
      ST_SATURATED    = 3'd5,
      ST_ABOVE_BOUND  = 3'd6
   } status_type;

   // What the back end has to do with a queued item.
   typedef enum logic [2:0] {
      K_PASS = 3'd0,
      K_MUL  = 3'd1,
      K_DIV  = 3'd2,
      K_POW  = 3'd3,
      K_ROOT = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      status_type status;
   } cls_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_MUL_GO,
      S_MUL_WAIT,
      S_DIV_GO,
      S_DIV_WAIT,
      S_POW_CHK,
      S_POW_WAIT,
      S_ROOT_INIT,
      S_ROOT_ITER,
      S_ROOT_PCHK,
      S_ROOT_PWAIT,
      S_ROOT_Q,
      S_ROOT_QWAIT,
      S_ROOT_T1,
      S_ROOT_T1W,
      S_ROOT_T2,
      S_ROOT_T2W,
      S_DONE
   } state_type;

endpackage

// File: src/frc_if.sv
// ----------------------------------------------------------------------------
// frc_req_if / frc_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface frc_req_if #(parameter int DATA_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [2:0]            opcode;
   logic [DATA_WIDTH-1:0] operand_a;
   logic [DATA_WIDTH-1:0] operand_b;

   modport source (output valid, output opcode, output operand_a, output operand_b,
                   input ready);
   modport sink (input valid, input opcode, input operand_a, input operand_b,
                 output ready);
endinterface

interface frc_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] result;
   logic [2:0]            status;

   modport source (output valid, output result, output status, input ready);
   modport sink (input valid, input result, input status, output ready);
endinterface

// File: src/frc_front.sv
// ----------------------------------------------------------------------------
// frc_front
// Accepts requests, settles add, subtract and all refusals at once, and
// classifies the rest for the back end.
// ----------------------------------------------------------------------------
module frc_front
   import frc_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int MAX_INDEX  = MAX_INDEX_DEF
) (
   frc_req_if.sink               req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output cls_type               q_cls,
   output logic [DATA_WIDTH-1:0] q_a,
   output logic [DATA_WIDTH-1:0] q_b
);
   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int NW = W - F;

   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   logic [W:0]    sum_w;
   logic [W:0]    dif_w;
   logic [W-1:0]  sum_val;
   logic [W-1:0]  dif_val;
   logic          sum_ovf;
   logic          dif_ovf;
   logic [NW-1:0] n_wide;
   logic          b_frac;
   logic          n_above;
   logic          a_neg;
   logic          b_neg;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   // Sign-extended sum and difference; overflow shows as a top-bit mismatch.
   assign a_neg   = req_chan.operand_a[W-1];
   assign b_neg   = req_chan.operand_b[W-1];
   assign sum_w   = {a_neg, req_chan.operand_a} + {b_neg, req_chan.operand_b};
   assign dif_w   = {a_neg, req_chan.operand_a} - {b_neg, req_chan.operand_b};
   assign sum_ovf = sum_w[W] != sum_w[W-1];
   assign dif_ovf = dif_w[W] != dif_w[W-1];
   assign sum_val = sum_ovf ? (sum_w[W] ? VMIN : VMAX) : sum_w[W-1:0];
   assign dif_val = dif_ovf ? (dif_w[W] ? VMIN : VMAX) : dif_w[W-1:0];

   // Integer part of the exponent or index and its checks.
   assign n_wide  = req_chan.operand_b[W-1:F];
   assign b_frac  = req_chan.operand_b[F-1:0] != '0;
   assign n_above = 64'(n_wide) > 64'(MAX_INDEX);

   // Classification.
   always_comb begin
      q_cls.kind   = K_PASS;
      q_cls.status = ST_OK;
      q_a          = '0;
      q_b          = req_chan.operand_b;
      case (opcode_type'(req_chan.opcode))
         OP_ADD: begin
            q_a = sum_val;
            if (sum_ovf) q_cls.status = ST_SATURATED;
         end
         OP_SUB: begin
            q_a = dif_val;
            if (dif_ovf) q_cls.status = ST_SATURATED;
         end
         OP_MUL: begin
            q_cls.kind = K_MUL;
            q_a        = req_chan.operand_a;
         end
         OP_DIV: begin
            if (req_chan.operand_b == '0) begin
               q_cls.status = ST_DIV_ZERO;
            end else begin
               q_cls.kind = K_DIV;
               q_a        = req_chan.operand_a;
            end
         end
         OP_POW: begin
            if (b_neg || b_frac) begin
               q_cls.status = ST_BAD_EXP;
            end else if (n_above) begin
               q_cls.status = ST_ABOVE_BOUND;
            end else begin
               q_cls.kind = K_POW;
               q_a        = req_chan.operand_a;
               q_b        = {{F{1'b0}}, n_wide};
            end
         end
         OP_ROOT: begin
            if (a_neg) begin
               q_cls.status = ST_NEG_RADICAND;
            end else if (b_neg || req_chan.operand_b == '0 || b_frac) begin
               q_cls.status = ST_BAD_INDEX;
            end else if (n_above) begin
               q_cls.status = ST_ABOVE_BOUND;
            end else if (req_chan.operand_a != '0) begin
               q_cls.kind = K_ROOT;
               q_a        = req_chan.operand_a;
               q_b        = {{F{1'b0}}, n_wide};
            end
         end
         default: begin
            q_cls.kind = K_PASS;
         end
      endcase
   end

endmodule

// File: src/frc_queue.sv
// ----------------------------------------------------------------------------
// frc_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module frc_queue
   import frc_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff;
   logic             wr_in;
   logic             rd_ff;
   logic             rd_in;
   logic [1:0]       cnt_ff;
   logic [1:0]       cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   // Pointer and count update.
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// File: src/frc_mul.sv
// ----------------------------------------------------------------------------
// frc_mul
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module frc_mul
   import frc_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   op_a,
   input  logic [WIDTH-1:0]   op_b,
   output logic               done,
   output logic [2*WIDTH-1:0] product
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] a_ff;
   logic [WIDTH-1:0] hi_ff;
   logic [WIDTH-1:0] lo_ff;
   logic [WIDTH-1:0] hi_in;
   logic [WIDTH-1:0] lo_in;
   logic [WIDTH:0]   sum;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

   // Add the multiplicand when the low bit is set, then shift right.
   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = op_b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[WIDTH:1];
         lo_in  = {sum[0], lo_ff[WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) a_ff <= op_a;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
   end

endmodule

// File: src/frc_div.sv
// ----------------------------------------------------------------------------
// frc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frc_div
   import frc_pkg::*;
#(
   parameter int NUM_WIDTH = 48,
   parameter int DEN_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numer,
   input  logic [DEN_WIDTH-1:0] denom,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient
);
   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic [NUM_WIDTH-1:0] num_ff;
   logic [NUM_WIDTH-1:0] num_in;
   logic [DEN_WIDTH-1:0] d_ff;
   logic [DEN_WIDTH-1:0] r_ff;
   logic [DEN_WIDTH-1:0] r_in;
   logic [DEN_WIDTH:0]   trial;
   logic [DEN_WIDTH:0]   diff;
   logic                 ge;
   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        cnt_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;

   assign done     = done_ff;
   assign quotient = num_ff;

   // Bring down the next numerator bit and subtract when it fits.
   always_comb begin
      trial   = {r_ff, num_ff[NUM_WIDTH-1]};
      diff    = trial - {1'b0, d_ff};
      ge      = trial >= {1'b0, d_ff};
      num_in  = num_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_WIDTH-2:0], ge};
         r_in   = ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) d_ff <= denom;
      num_ff <= num_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

endmodule

// File: src/frc_back.sv
// ----------------------------------------------------------------------------
// frc_back
// Carries out multiply, divide, power and Newton root on a shared serial
// multiplier and divider, and holds the result register.
// ----------------------------------------------------------------------------
module frc_back
   import frc_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int MAX_INDEX  = MAX_INDEX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  cls_type               q_cls,
   input  logic [DATA_WIDTH-1:0] q_a,
   input  logic [DATA_WIDTH-1:0] q_b,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_WIDTH-1:0]  csr_wdata,
   frc_rsp_if.source             rsp_chan
);
   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int NW = W + F;
   localparam int PW = 2 * W;
   localparam int VW = PW - F;
   localparam int IW = $clog2(MAX_INDEX + 1);

   localparam logic [W-1:0] VMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN    = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ONE     = W'(1) << F;
   localparam logic [W-1:0] ONE_ULP = W'(1);

   // Configuration registers.
   logic [TOL_WIDTH-1:0]  tol_ff;
   logic [ITER_WIDTH-1:0] maxit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_RESET;
         maxit_ff <= ITER_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_TOLERANCE:      tol_ff   <= csr_wdata;
            REG_MAX_ITERATIONS: maxit_ff <= csr_wdata[ITER_WIDTH-1:0];
            default:            tol_ff   <= tol_ff;
         endcase
      end
   end

   state_type             state_ff, state_in;
   logic [W-1:0]          a_ff, a_in, b_ff, b_in;
   logic                  neg_ff, neg_in;
   logic [W-1:0]          m_ff, m_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [ITER_WIDTH-1:0] it_ff, it_in;
   logic [W-1:0]          x_ff, x_in, p_ff, p_in, q_ff, q_in, t1_ff, t1_in;
   logic [W-1:0]          res_ff, res_in;
   status_type            st_ff, st_in;
   logic                  out_valid_ff, out_valid_in;
   logic [W-1:0]          out_res_ff, out_res_in;
   status_type            out_st_ff, out_st_in;

   logic          mul_start, mul_done;
   logic [W-1:0]  mul_a, mul_b;
   logic [PW-1:0] mul_prod;
   logic          div_start, div_done;
   logic [NW-1:0] div_num, div_quo;
   logic [W-1:0]  div_den;

   frc_mul #(.WIDTH(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   frc_div #(.NUM_WIDTH(NW), .DEN_WIDTH(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Operand magnitudes and the index.
   logic          a_neg, b_neg;
   logic [W-1:0]  ma, mb;
   logic [IW-1:0] n;

   assign a_neg = a_ff[W-1];
   assign b_neg = b_ff[W-1];
   assign ma    = a_neg ? W'(-a_ff) : a_ff;
   assign mb    = b_neg ? W'(-b_ff) : b_ff;
   assign n     = b_ff[IW-1:0];

   // Scaled product and quotient with their saturation limits.
   logic          prod_neg, prod_sat, prod_over;
   logic [W-1:0]  prod_lim, prod_val;
   logic [VW-1:0] prod_v;
   logic          quo_neg, quo_sat, quo_over;
   logic [W-1:0]  quo_lim, quo_val;

   assign prod_v    = mul_prod[PW-1:F];
   assign prod_neg  = (state_ff == S_POW_WAIT) ? (neg_ff ^ a_neg) : (a_neg ^ b_neg);
   assign prod_lim  = prod_neg ? VMIN : VMAX;
   assign prod_sat  = prod_v > VW'(prod_lim);
   assign prod_over = prod_v > VW'(VMAX);
   assign prod_val  = prod_neg ? W'(-prod_v[W-1:0]) : prod_v[W-1:0];

   assign quo_neg  = a_neg ^ b_neg;
   assign quo_lim  = quo_neg ? VMIN : VMAX;
   assign quo_sat  = div_quo > NW'(quo_lim);
   assign quo_over = div_quo > NW'(VMAX);
   assign quo_val  = quo_neg ? W'(-div_quo[W-1:0]) : div_quo[W-1:0];

   // Newton update: x - x/n + q/n, clamped to one ulp .. maximum.
   logic [W:0]   nx_w;
   logic [W-1:0] nx, step;

   always_comb begin
      nx_w = {1'b0, x_ff} - {1'b0, t1_ff} + {1'b0, div_quo[W-1:0]};
      if (nx_w > {1'b0, VMAX}) nx = VMAX;
      else if (nx_w == '0)     nx = ONE_ULP;
      else                     nx = nx_w[W-1:0];
      step = (nx > x_ff) ? (nx - x_ff) : (x_ff - nx);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      neg_in       = neg_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      it_in        = it_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      t1_in        = t1_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_res_in   = out_res_ff;
      out_st_in    = out_st_ff;
      q_pop        = 1'b0;
      mul_start    = 1'b0;
      mul_a        = ma;
      mul_b        = mb;
      div_start    = 1'b0;
      div_num      = {ma, {F{1'b0}}};
      div_den      = mb;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               a_in   = q_a;
               b_in   = q_b;
               res_in = q_a;
               st_in  = q_cls.status;
               case (q_cls.kind)
                  K_MUL:  state_in = S_MUL_GO;
                  K_DIV:  state_in = S_DIV_GO;
                  K_POW: begin
                     m_in     = ONE;
                     neg_in   = 1'b0;
                     k_in     = '0;
                     state_in = S_POW_CHK;
                  end
                  K_ROOT: state_in = S_ROOT_INIT;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               res_in   = prod_sat ? (prod_neg ? VMIN : VMAX) : prod_val;
               st_in    = prod_sat ? ST_SATURATED : ST_OK;
               state_in = S_DONE;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               res_in   = quo_sat ? (quo_neg ? VMIN : VMAX) : quo_val;
               st_in    = quo_sat ? ST_SATURATED : ST_OK;
               state_in = S_DONE;
            end
         end
         // Power: multiply the running magnitude by the base n times.
         S_POW_CHK: begin
            if (k_ff == n) begin
               res_in   = neg_ff ? W'(-m_ff) : m_ff;
               st_in    = ST_OK;
               state_in = S_DONE;
            end else begin
               mul_start = 1'b1;
               mul_a     = m_ff;
               mul_b     = ma;
               state_in  = S_POW_WAIT;
            end
         end
         S_POW_WAIT: begin
            if (mul_done) begin
               if (prod_sat) begin
                  res_in   = (a_neg && n[0]) ? VMIN : VMAX;
                  st_in    = ST_SATURATED;
                  state_in = S_DONE;
               end else begin
                  m_in     = prod_v[W-1:0];
                  neg_in   = prod_neg && (prod_v[W-1:0] != '0);
                  k_in     = k_ff + 1'b1;
                  state_in = S_POW_CHK;
               end
            end
         end
         // Root: start from half the radicand, at least one ulp.
         S_ROOT_INIT: begin
            x_in     = (a_ff[W-1:1] == '0) ? ONE_ULP : {1'b0, a_ff[W-1:1]};
            it_in    = '0;
            state_in = S_ROOT_ITER;
         end
         S_ROOT_ITER: begin
            if (it_ff == maxit_ff) begin
               res_in   = x_ff;
               st_in    = ST_OK;
               state_in = S_DONE;
            end else begin
               p_in     = ONE;
               k_in     = IW'(1);
               state_in = S_ROOT_PCHK;
            end
         end
         S_ROOT_PCHK: begin
            if (k_ff == n) begin
               state_in = S_ROOT_Q;
            end else begin
               mul_start = 1'b1;
               mul_a     = p_ff;
               mul_b     = x_ff;
               state_in  = S_ROOT_PWAIT;
            end
         end
         S_ROOT_PWAIT: begin
            if (mul_done) begin
               p_in     = prod_over ? VMAX : prod_v[W-1:0];
               k_in     = k_ff + 1'b1;
               state_in = S_ROOT_PCHK;
            end
         end
         S_ROOT_Q: begin
            if (p_ff == '0) begin
               q_in     = VMAX;
               state_in = S_ROOT_T1;
            end else begin
               div_start = 1'b1;
               div_num   = {a_ff, {F{1'b0}}};
               div_den   = p_ff;
               state_in  = S_ROOT_QWAIT;
            end
         end
         S_ROOT_QWAIT: begin
            if (div_done) begin
               q_in     = quo_over ? VMAX : div_quo[W-1:0];
               state_in = S_ROOT_T1;
            end
         end
         S_ROOT_T1: begin
            div_start = 1'b1;
            div_num   = {{F{1'b0}}, x_ff};
            div_den   = W'(n);
            state_in  = S_ROOT_T1W;
         end
         S_ROOT_T1W: begin
            if (div_done) begin
               t1_in    = div_quo[W-1:0];
               state_in = S_ROOT_T2;
            end
         end
         S_ROOT_T2: begin
            div_start = 1'b1;
            div_num   = {{F{1'b0}}, q_ff};
            div_den   = W'(n);
            state_in  = S_ROOT_T2W;
         end
         S_ROOT_T2W: begin
            if (div_done) begin
               x_in  = nx;
               it_in = it_ff + 1'b1;
               if (step < W'(tol_ff)) begin
                  res_in   = nx;
                  st_in    = ST_OK;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ROOT_ITER;
               end
            end
         end
         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_res_in   = res_ff;
               out_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      neg_ff     <= neg_in;
      m_ff       <= m_in;
      k_ff       <= k_in;
      it_ff      <= it_in;
      x_ff       <= x_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      t1_ff      <= t1_in;
      res_ff     <= res_in;
      st_ff      <= st_in;
      out_res_ff <= out_res_in;
      out_st_ff  <= out_st_in;
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.result = out_res_ff;
   assign rsp_chan.status = out_st_ff;

endmodule

// File: src/fixed_point_calculator_nth_root.sv
// ----------------------------------------------------------------------------
// fixed_point_calculator_nth_root
// Signed fixed-point calculator: add, subtract, multiply, divide, integer
// power and Newton nth root, with saturation and error status.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    opcode, operand_a, operand_b
//   rsp_chan  out        valid/ready    result, status
//   csr_*     in         write enable   csr_index, csr_wdata
//
// Add, subtract and refused requests are settled in the front end. Multiply
// and divide run on the serial units (W data bits, F fraction bits). Power
// repeats the multiply up to n times; each Newton step of the root takes
// n-1 multiplies and up to three divides, up to max_iterations steps.
// Reset is synchronous and needs no clearing pass. A two-entry queue lets
// requests be accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
module fixed_point_calculator_nth_root
   import frc_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int MAX_INDEX  = MAX_INDEX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   frc_req_if.sink              req_chan,
   frc_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);
   localparam int W  = DATA_WIDTH;
   localparam int QW = $bits(cls_type) + 2 * W;

   logic          q_push, q_full, q_pop, q_empty;
   cls_type       f_cls, b_cls;
   logic [W-1:0]  f_a, f_b, b_a, b_b;
   logic [QW-1:0] b_data;

   frc_front #(
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_INDEX  (MAX_INDEX)
   ) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cls    (f_cls),
      .q_a      (f_a),
      .q_b      (f_b)
   );

   frc_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_cls, f_a, f_b}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (b_data),
      .empty     (q_empty)
   );

   assign {b_cls, b_a, b_b} = b_data;

   frc_back #(
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_INDEX  (MAX_INDEX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_cls     (b_cls),
      .q_a       (b_a),
      .q_b       (b_b),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_chan  (rsp_chan)
   );

endmodule
